/* hdl/lale_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lale_pkg
// Shared constants for the line assembler: keywords, line terminators,
// result kind codes and reset values.
// ----------------------------------------------------------------------------
package lale_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 64;

  localparam int unsigned KW_LEN  = 7;
  localparam int unsigned KW_BITS = 8 * KW_LEN;

  // "OK+CONN" and "OK+LOST", first character in the top byte
  localparam logic [KW_BITS-1:0] KW_CONN = 56'h4F4B2B434F4E4E;
  localparam logic [KW_BITS-1:0] KW_LOST = 56'h4F4B2B4C4F5354;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam int unsigned MAXLEN_W = 7;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 7'd64;
  localparam logic [MAXLEN_W-1:0] MAXLEN_MIN = 7'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } st_t;

endpackage
`default_nettype wire

/* hdl/line_assembler_with_link_events.sv */
`default_nettype none
// A status or empty-line result is registered in the output slot at the input
//   transfer; line bytes pass through the RAM read register on their way out.
// Throughput: one byte per cycle while the output slot is free; input stalls
//   while a line drains from the line store.
// Reset (synchronous, rst_n low): store empty, link down, max length 64; the
//   line store RAM is not cleared, the fill count guards it.
// ----------------------------------------------------------------------------
// line_assembler_with_link_events
// Appends received bytes to a line store held in a synchronous RAM, watches
// for the link keywords and emits completed lines byte by byte.
// ----------------------------------------------------------------------------
module line_assembler_with_link_events #(
  parameter int unsigned LINE_DEPTH = lale_pkg::LINE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // results
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_line_byte,
  output logic            out_last,
  output logic            out_connected,
  // configuration
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [lale_pkg::MAXLEN_W-1:0] cfg_max_line_length
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned CW = (AW > lale_pkg::MAXLEN_W) ? AW : lale_pkg::MAXLEN_W;
  localparam int unsigned RW = lale_pkg::KW_BITS;

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  lale_pkg::st_t st_r;
  logic [AW-1:0] fill_r;        // bytes currently held in the store
  logic [RW-1:0] recent_r;      // last seven stored bytes, newest lowest
  logic          zseen_r;       // a zero byte sits in the store
  logic [AW-1:0] zpos_r;        // index of the first zero byte
  logic          link_r;
  logic [lale_pkg::MAXLEN_W-1:0] maxlen_r;

  // drain sequencer
  logic [AW-1:0] rd_cnt_r;      // next store index to read
  logic [AW-1:0] km1_r;         // index of the final byte of the line
  logic          rd_done_r;     // all line bytes have been read
  logic          pend_r;        // ram_q_r holds a byte not yet in the output
  logic          pend_last_r;
  logic [7:0]    ram_q_r;

  // output register
  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_conn_r;

  // line store
  logic [7:0] mem [LINE_DEPTH];

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic out_free;
  logic in_xfer;
  logic drain_issue;
  logic drain_load;

  // the output slot can take a new result this cycle
  assign out_free  = !out_valid_r || !out_stall;
  // one item at a time: no new byte while a line drains or a full slot is stalled
  assign in_stall  = (st_r == lale_pkg::ST_DRAIN) || !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = (st_r == lale_pkg::ST_IDLE);

  // read the next line byte when the data register is free or being emptied
  assign drain_issue = (st_r == lale_pkg::ST_DRAIN) && !rd_done_r && (!pend_r || out_free);
  assign drain_load  = pend_r && out_free;

  // --------------------------------------------------------------------------
  // Append stage: what the store looks like after this byte goes in
  // --------------------------------------------------------------------------
  logic          app_wr;
  logic [AW-1:0] app_fill;
  logic [RW-1:0] app_recent;
  logic          app_zseen;
  logic [AW-1:0] app_zpos;

  always_comb begin
    app_wr     = 1'b0;
    app_fill   = '0;
    app_recent = '0;
    app_zseen  = 1'b0;
    app_zpos   = zpos_r;
    if (fill_r != AW'(LINE_DEPTH - 1)) begin
      app_wr     = 1'b1;
      app_fill   = fill_r + AW'(1);
      app_recent = {recent_r[RW-9:0], in_rx_byte};
      app_zseen  = zseen_r;
      if (in_rx_byte == lale_pkg::CHAR_NUL && !zseen_r) begin
        app_zseen = 1'b1;
        app_zpos  = fill_r;
      end
    end
    // full store: byte dropped and the store empties
  end

  // --------------------------------------------------------------------------
  // Decision stage: keywords, terminators, line length
  // --------------------------------------------------------------------------
  logic          kw_arm;
  logic          is_term;
  logic [CW-1:0] lim_ext;
  logic [CW-1:0] end_ext;
  logic [CW-1:0] k_len;

  assign kw_arm  = !app_zseen && (app_fill >= AW'(lale_pkg::KW_LEN));
  assign is_term = (in_rx_byte == lale_pkg::CHAR_LF) || (in_rx_byte == lale_pkg::CHAR_CR);
  assign lim_ext = CW'(maxlen_r - lale_pkg::MAXLEN_W'(1));
  // a zero byte always lies below the fill count, so it ends the line first
  assign end_ext = app_zseen ? CW'(app_zpos) : CW'(app_fill);
  assign k_len   = (end_ext < lim_ext) ? end_ext : lim_ext;

  logic          commit;        // state follows the append/decision result
  logic          clr;
  logic          link_nxt;
  logic          start_drain;
  logic [1:0]    res_kind;

  always_comb begin
    commit      = 1'b0;
    clr         = 1'b0;
    link_nxt    = link_r;
    start_drain = 1'b0;
    res_kind    = lale_pkg::KIND_STATUS;
    if (maxlen_r >= lale_pkg::MAXLEN_MIN) begin
      commit = 1'b1;
      if (kw_arm && app_recent == lale_pkg::KW_CONN) begin
        link_nxt = 1'b1;
        clr      = 1'b1;
      end else if (kw_arm && app_recent == lale_pkg::KW_LOST) begin
        link_nxt = 1'b0;
        clr      = 1'b1;
      end else if (is_term) begin
        clr = 1'b1;
        if (app_fill > AW'(1)) begin
          if (k_len == '0) begin
            res_kind = lale_pkg::KIND_EMPTY;
          end else begin
            start_drain = 1'b1;
          end
        end
      end
    end
    // max length below two: byte ignored, status only
  end

  // --------------------------------------------------------------------------
  // Line store RAM: one write port at the fill index, one registered read
  // port for draining. A byte written at a transfer is read no earlier than
  // the following cycle, so no forwarding is needed.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer && commit && app_wr) begin
      mem[fill_r] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_issue) begin
      ram_q_r <= mem[rd_cnt_r];
    end
  end

  // --------------------------------------------------------------------------
  // Control and output registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= lale_pkg::ST_IDLE;
      fill_r      <= '0;
      recent_r    <= '0;
      zseen_r     <= 1'b0;
      link_r      <= 1'b0;
      maxlen_r    <= lale_pkg::MAXLEN_RST;
      rd_done_r   <= 1'b1;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        maxlen_r <= cfg_max_line_length;
      end

      // slot fills from a byte transfer that starts no drain or a drained byte, else empties once taken
      if ((in_xfer && !start_drain) || drain_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (in_xfer) begin
        if (commit) begin
          fill_r   <= clr ? '0 : app_fill;
          recent_r <= clr ? '0 : app_recent;
          zseen_r  <= clr ? 1'b0 : app_zseen;
          zpos_r   <= app_zpos;
          link_r   <= link_nxt;
        end
        if (start_drain) begin
          st_r      <= lale_pkg::ST_DRAIN;
          rd_cnt_r  <= '0;
          rd_done_r <= 1'b0;
          km1_r     <= AW'(k_len - CW'(1));
        end else begin
          out_kind_r  <= res_kind;
          out_byte_r  <= '0;
          out_last_r  <= 1'b1;
          out_conn_r  <= link_nxt;
        end
      end

      // drain: read side
      if (drain_issue) begin
        rd_cnt_r    <= rd_cnt_r + AW'(1);
        rd_done_r   <= (rd_cnt_r == km1_r);
        pend_last_r <= (rd_cnt_r == km1_r);
      end

      // drain: move the read byte into the output slot
      if (drain_issue) begin
        pend_r <= 1'b1;
      end else if (drain_load) begin
        pend_r <= 1'b0;
      end

      if (drain_load) begin
        out_kind_r  <= lale_pkg::KIND_BYTE;
        out_byte_r  <= ram_q_r;
        out_last_r  <= pend_last_r;
        out_conn_r  <= link_r;
        if (pend_last_r) begin
          st_r <= lale_pkg::ST_IDLE;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_line_byte = out_byte_r;
  assign out_last      = out_last_r;
  assign out_connected = out_conn_r;

endmodule
`default_nettype wire

/* tb/tb_line_assembler_with_link_events.sv */
// ----------------------------------------------------------------------------
// tb_line_assembler_with_link_events
// Self-checking bench for the serial line assembler. Bytes go in through a
// queue-fed driver. A shadow copy of the line store, keyword window and link
// flag predicts every result. The monitor matches each output transfer against
// the oldest prediction. Both sides idle at random. The length register is
// swept through its extremes between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_line_assembler_with_link_events;

  localparam int unsigned DEPTH       = lale_pkg::LINE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned SETTLE      = 4;   // cycles after the last result before a cfg write
  localparam int unsigned TAIL        = 20;  // cycles watched after the run for stray results

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] line_byte;
    logic       last;
    logic       connected;
  } line_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; the inputs are known from time zero
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_kind;
  logic [7:0]          out_line_byte;
  logic                out_last;
  logic                out_connected;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [lale_pkg::MAXLEN_W-1:0] cfg_max_line_length = lale_pkg::MAXLEN_RST;

  line_assembler_with_link_events #(
    .LINE_DEPTH(DEPTH)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_line_byte       (out_line_byte),
    .out_last            (out_last),
    .out_connected       (out_connected),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_line_length (cfg_max_line_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow state of the assembler
  // --------------------------------------------------------------------------
  logic [7:0]          shadow_line [DEPTH];
  int unsigned         shadow_fill;
  logic [lale_pkg::KW_BITS-1:0]  shadow_window;   // last seven stored bytes, newest low
  logic                shadow_zero;
  logic                shadow_link;
  logic [lale_pkg::MAXLEN_W-1:0] shadow_max_len;

  line_result_t expected_results [$];
  logic [7:0]   pending_bytes [$];

  int unsigned issued_bytes   = 0;  // popped by the driver
  int unsigned accepted_bytes = 0;  // transferred into the block
  int unsigned queued_in_phase = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;         // when set, neither side idles

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] b,
                                      input logic last);
    line_result_t r;
    r.kind      = kind;
    r.line_byte = b;
    r.last      = last;
    r.connected = shadow_link;
    expected_results.push_back(r);
  endfunction

  function automatic void clear_line();
    shadow_fill   = 0;
    shadow_window = '0;
    shadow_zero   = 1'b0;
  endfunction

  // Works out every result that one received byte causes.
  function automatic void assemble_byte(input logic [7:0] b);
    int unsigned cut, n;
    // length register below two: byte ignored entirely
    if (shadow_max_len < lale_pkg::MAXLEN_MIN) begin
      push_result(lale_pkg::KIND_STATUS, 8'h00, 1'b1);
      return;
    end
    // store full: byte dropped, store cleared, byte still seen as terminator
    if (shadow_fill < DEPTH - 1) begin
      shadow_line[shadow_fill] = b;
      shadow_fill++;
      shadow_window = {shadow_window[lale_pkg::KW_BITS-9:0], b};
      if (b == lale_pkg::CHAR_NUL) shadow_zero = 1'b1;
    end else begin
      clear_line();
    end
    // a stored zero byte masks keywords until the next clear
    if (!shadow_zero && shadow_fill >= lale_pkg::KW_LEN) begin
      if (shadow_window == lale_pkg::KW_CONN) begin
        shadow_link = 1'b1;
        clear_line();
        push_result(lale_pkg::KIND_STATUS, 8'h00, 1'b1);
        return;
      end
      if (shadow_window == lale_pkg::KW_LOST) begin
        shadow_link = 1'b0;
        clear_line();
        push_result(lale_pkg::KIND_STATUS, 8'h00, 1'b1);
        return;
      end
    end
    if (b == lale_pkg::CHAR_LF || b == lale_pkg::CHAR_CR) begin
      if (shadow_fill > 1) begin
        cut = shadow_max_len - 1;
        n = 0;
        while (n < shadow_fill && n < cut && shadow_line[n] != lale_pkg::CHAR_NUL) n++;
        clear_line();
        if (n == 0) begin
          // line opens with a zero byte
          push_result(lale_pkg::KIND_EMPTY, 8'h00, 1'b1);
          return;
        end
        for (int unsigned i = 0; i < n; i++)
          push_result(lale_pkg::KIND_BYTE, shadow_line[i], (i + 1 == n));
        return;
      end
      clear_line();
    end
    push_result(lale_pkg::KIND_STATUS, 8'h00, 1'b1);
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one transfer per edge when valid and not stalled
  // --------------------------------------------------------------------------
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        assemble_byte(in_rx_byte);
        accepted_bytes++;
      end
      // payload holds while stalled; only move on after a transfer or when idle
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_rx_byte <= pending_bytes.pop_front();
          in_valid   <= 1'b1;
          issued_bytes++;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and random back-pressure
  // --------------------------------------------------------------------------
  int unsigned out_hold = 0;

  always @(posedge clk) begin
    line_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d line_byte %0h last %0d connected %0d",
                 out_kind, out_line_byte, out_last, out_connected);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_kind);
            errors++;
          end
          if (out_line_byte !== want.line_byte) begin
            $error("line_byte: expected %0h, actual %0h", want.line_byte, out_line_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            errors++;
          end
          if (out_connected !== want.connected) begin
            $error("connected: expected %0d, actual %0d", want.connected, out_connected);
            errors++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) out_hold = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("line_assembler_with_link_events: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_in_phase++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_printable(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom_range(8'h20, 8'h7E)));
  endfunction

  function automatic void push_terminator();
    case ($urandom_range(0, 3))
      0:       push_byte(lale_pkg::CHAR_CR);
      1:       push_byte(lale_pkg::CHAR_LF);
      2: begin
        push_byte(lale_pkg::CHAR_CR);
        push_byte(lale_pkg::CHAR_LF);
      end
      default: push_byte(lale_pkg::CHAR_LF);
    endcase
  endfunction

  // keyword, now and then with one character spoiled
  function automatic void push_keyword();
    string kw;
    int unsigned spoil;
    kw = $urandom_range(0, 1) ? "OK+CONN" : "OK+LOST";
    spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lale_pkg::KW_LEN - 1)
                                        : lale_pkg::KW_LEN;
    for (int unsigned i = 0; i < lale_pkg::KW_LEN; i++)
      push_byte((i == spoil) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'(kw[i]));
  endfunction

  // One random sequence; mostly well-formed lines and keywords.
  function automatic void push_chunk();
    int unsigned r;
    int          n;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      push_printable($urandom_range(0, 10));
      push_terminator();
    end else if (r < 60) begin
      push_printable($urandom_range(0, 4));
      push_keyword();
    end else if (r < 70) begin
      // zero byte inside the line, sometimes followed by a keyword it must mask
      push_printable($urandom_range(0, 5));
      push_byte(lale_pkg::CHAR_NUL);
      if ($urandom_range(0, 1)) push_keyword();
      push_printable($urandom_range(0, 3));
      push_terminator();
    end else if (r < 82) begin
      // raw noise covers every bit pattern
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end else if (r < 86) begin
      // long line around the store depth, can reach the store-full drop
      push_printable($urandom_range(DEPTH - 6, DEPTH + 6));
      push_terminator();
    end else if (r < 93) begin
      // length right around the output cut
      n = int'(shadow_max_len) + int'($urandom_range(0, 4)) - 3;
      if (n < 0) n = 0;
      if (n > DEPTH + 2) n = DEPTH + 2;
      push_printable(unsigned'(n));
      push_terminator();
    end else begin
      push_terminator();
    end
  endfunction

  // Block is idle when every byte went in and every result came out.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || issued_bytes != accepted_bytes ||
           expected_results.size() != 0);
  endtask

  task automatic write_max_len(input logic [lale_pkg::MAXLEN_W-1:0] value);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    cfg_max_line_length <= value;
    cfg_valid           <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    // transfer happened at this edge
    shadow_max_len = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [lale_pkg::MAXLEN_W-1:0] value,
                           input int unsigned count, input bit no_idle);
    write_max_len(value);
    calm = no_idle;
    queued_in_phase = 0;
    while (queued_in_phase < count) push_chunk();
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    clear_line();
    shadow_link    = 1'b0;
    shadow_max_len = lale_pkg::MAXLEN_RST;
    for (int i = 0; i < DEPTH; i++) shadow_line[i] = 8'h00;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: plain line, connect, empty line, masked keyword, disconnect
    push_text("AB");
    push_byte(lale_pkg::CHAR_CR);
    push_text("OK+CONN");
    push_byte(lale_pkg::CHAR_NUL);
    push_byte(lale_pkg::CHAR_LF);
    push_byte(lale_pkg::CHAR_NUL);
    push_text("OK+LOST");
    push_byte(lale_pkg::CHAR_CR);
    push_text("OK+LOST");
    push_byte(8'hFF);
    push_byte(lale_pkg::CHAR_LF);
    wait_idle();

    // sweep of the length register; 0 and 1 make the block ignore bytes
    run_phase(lale_pkg::MAXLEN_MIN, 30, 1'b0);
    run_phase(7'd0, 6, 1'b0);
    run_phase(7'd1, 6, 1'b0);
    run_phase(7'd127, 45, 1'b1);
    run_phase(7'd3, 30, 1'b0);
    run_phase(7'($urandom_range(4, 63)), 55, 1'b0);
    run_phase(lale_pkg::MAXLEN_RST, 60, 1'b0);

    repeat (TAIL) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("line_assembler_with_link_events: match");
    end else begin
      $display("line_assembler_with_link_events: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lale_pkg.sv
hdl/line_assembler_with_link_events.sv
tb/tb_line_assembler_with_link_events.sv
